// File: hw/rtl/skin_masked_box_smoothing_core_macros.svh
// ----------------------------------------------------------------------------
// skin masked box smoothing core: assertion macros
// shared property wrappers, clocked on clk with arst_n as disable
// ----------------------------------------------------------------------------
`ifndef SKIN_MASKED_BOX_SMOOTHING_CORE_MACROS_SVH
`define SKIN_MASKED_BOX_SMOOTHING_CORE_MACROS_SVH

// same-cycle implication
`define SKMBS_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("skmbs assertion failed");

// next-cycle implication
`define SKMBS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("skmbs assertion failed");

`endif

// File: hw/rtl/skmbs_pkg.sv
// ----------------------------------------------------------------------------
// skmbs_pkg
// shared types and constants of the skin masked box smoothing core
// ----------------------------------------------------------------------------
package skmbs_pkg;

	localparam int KERNEL_SIZE_DEF = 7;
	localparam int MAX_WIDTH_DEF   = 1024;
	localparam int MAX_HEIGHT_DEF  = 2048;
	localparam int QUEUE_DEPTH     = 4;

	localparam int PIX_W      = 8;
	localparam int PX_W       = 3 * PIX_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 18;

	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_B = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_G = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_R = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DIST_MAX = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 3'd5;

	localparam logic [7:0]  RST_CENTER_B = 8'd148;
	localparam logic [7:0]  RST_CENTER_G = 8'd161;
	localparam logic [7:0]  RST_CENTER_R = 8'd198;
	localparam logic [17:0] RST_DIST_MAX = 18'd5312;
	localparam logic [10:0] RST_WIDTH    = 11'd1024;
	localparam logic [11:0] RST_HEIGHT   = 12'd768;

	typedef struct packed {
		logic [7:0]  center_b;
		logic [7:0]  center_g;
		logic [7:0]  center_r;
		logic [17:0] dist_sq_max;
		logic [10:0] width;
		logic [11:0] height;
	} cfg_t;

	// px packed b in the low byte, then g, then r
	typedef struct packed {
		logic            is_pixel;
		logic [PX_W-1:0] px;
	} item_t;

endpackage

// File: hw/rtl/skmbs_queue.sv
// ----------------------------------------------------------------------------
// skmbs_queue
// front end: accepts input beats, classifies them, short fifo to the back end
// ----------------------------------------------------------------------------
`include "skin_masked_box_smoothing_core_macros.svh"

module skmbs_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [skmbs_pkg::PX_W-1:0]  s_axis_tdata,
	input  logic                        s_axis_tuser,
	output logic                        q_valid,
	input  logic                        q_ready,
	output skmbs_pkg::item_t            q_item
);

	localparam int DEPTH = skmbs_pkg::QUEUE_DEPTH;
	localparam int PW    = $clog2(DEPTH);
	localparam int CNTW  = $clog2(DEPTH + 1);

	skmbs_pkg::item_t fifo_q [DEPTH];
	logic [PW-1:0]    wp_q, rp_q;
	logic [CNTW-1:0]  cnt_q;
	logic             push, pop;
	skmbs_pkg::item_t in_item;

	assign in_item.is_pixel = ~s_axis_tuser;
	assign in_item.px       = s_axis_tdata;

	assign s_axis_tready = (cnt_q != CNTW'(DEPTH));
	assign q_valid       = (cnt_q != '0);
	assign q_item        = fifo_q[rp_q];
	assign push          = s_axis_tvalid && s_axis_tready;
	assign pop           = q_valid && q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wp_q] <= in_item;
		end
	end

	`SKMBS_ASSERT_IMPL(a_q_count, 1'b1, cnt_q <= CNTW'(DEPTH))

endmodule

// File: hw/rtl/skmbs_div.sv
// ----------------------------------------------------------------------------
// skmbs_div
// three-lane restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module skmbs_div #(
	parameter int NUM_W = 12,
	parameter int DEN_W = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num [3],
	input  logic [DEN_W-1:0] den,
	output logic             busy,
	output logic             done,
	output logic [NUM_W-1:0] quo [3]
);

	localparam int CW = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] quo_q [3];
	logic [DEN_W:0]   rem_q [3];
	logic [DEN_W-1:0] den_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q, done_q;
	logic [DEN_W+1:0] trial [3];

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			trial[ch] = {rem_q[ch], quo_q[ch][NUM_W-1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(NUM_W);
			den_q  <= den;
			for (int ch = 0; ch < 3; ch++) begin
				quo_q[ch] <= num[ch];
				rem_q[ch] <= '0;
			end
		end else if (busy_q) begin
			for (int ch = 0; ch < 3; ch++) begin
				if (trial[ch] >= {2'b00, den_q}) begin
					rem_q[ch] <= (DEN_W+1)'(trial[ch] - {2'b00, den_q});
					quo_q[ch] <= {quo_q[ch][NUM_W-2:0], 1'b1};
				end else begin
					rem_q[ch] <= trial[ch][DEN_W:0];
					quo_q[ch] <= {quo_q[ch][NUM_W-2:0], 1'b0};
				end
			end
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = quo_q;

endmodule

// File: hw/rtl/skmbs_core.sv
// ----------------------------------------------------------------------------
// skmbs_core
// back end: line buffers, column sums, box mean, skin test, output register
// ----------------------------------------------------------------------------
`include "skin_masked_box_smoothing_core_macros.svh"

module skmbs_core #(
	parameter int KERNEL_SIZE = skmbs_pkg::KERNEL_SIZE_DEF,
	parameter int MAX_WIDTH   = skmbs_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT  = skmbs_pkg::MAX_HEIGHT_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  skmbs_pkg::cfg_t            cfg,
	input  logic                       item_valid,
	output logic                       item_ready,
	input  skmbs_pkg::item_t           item,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [skmbs_pkg::PX_W-1:0] m_axis_tdata,
	output logic                       m_axis_tuser,
	output logic                       m_axis_tlast
);

	localparam int RAD   = KERNEL_SIZE / 2;
	localparam int WIN   = 2 * RAD + 1;
	localparam int RING  = 2 * RAD;
	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int FWW   = $clog2(MAX_WIDTH + 1);
	localparam int FHW   = $clog2(MAX_HEIGHT + 1);
	localparam int RW    = $clog2(MAX_HEIGHT + KERNEL_SIZE + 2);
	localparam int NW    = $clog2(MAX_WIDTH * (MAX_HEIGHT + KERNEL_SIZE) + 1);
	localparam int SW    = $clog2(RING);
	localparam int MDEP  = RING * MAX_WIDTH;
	localparam int MAW   = $clog2(MDEP);
	localparam int CSW   = $clog2(WIN * 255 + 1);
	localparam int ACW   = $clog2(WIN * WIN * 255 + 1);
	localparam int DVW   = $clog2(WIN * WIN + 1);
	localparam int DCW   = $clog2(RING + 2);
	localparam int PW    = skmbs_pkg::PIX_W;
	localparam int PXW   = skmbs_pkg::PX_W;

	typedef enum logic [3:0] {
		S_IDLE, S_CHK, S_RD, S_AC, S_EMIT, S_CTR, S_DSTART, S_DIV, S_WR
	} state_t;

	state_t            state_q;
	logic              active_q;
	logic [FWW-1:0]    fw_q;
	logic [FHW-1:0]    fh_q;
	logic [NW-1:0]     delay_q, n_q;
	logic [CW-1:0]     in_col_q, out_col_q;
	logic [RW-1:0]     in_row_q, out_row_q;
	logic [SW-1:0]     in_slot_q, out_slot_q, rslot_q;
	logic [DCW-1:0]    d_q;
	logic              inc_q, real_q;
	skmbs_pkg::item_t  item_q;
	logic [CSW-1:0]    sum_q [3];
	logic [CSW-1:0]    win_q [WIN][3];
	logic [PXW-1:0]    centre_q;
	logic              skin_q;
	logic [ACW-1:0]    acc_q [3];
	logic [DVW-1:0]    dvs_q;

	logic [PXW-1:0]    mem_q [MDEP];
	logic [PXW-1:0]    rdata_q;
	logic [MAW-1:0]    raddr, waddr;
	logic              mem_we;

	logic              m_valid_q, m_user_q, m_last_q;
	logic [PXW-1:0]    m_data_q;

	logic              div_start, div_busy, div_done;
	logic [ACW-1:0]    div_quo [3];

	logic [31:0]       w32, h32, fw_new, fh_new;
	logic              load, last_w;
	logic [ACW-1:0]    acc_w [3];
	logic [DVW-1:0]    dvs_w;
	logic              skin_w;

	// frame size latch
	always_comb begin
		w32 = 32'(cfg.width);
		h32 = 32'(cfg.height);
		fw_new = (w32 < 32'd1) ? 32'd1 : ((w32 > MAX_WIDTH) ? 32'(MAX_WIDTH) : w32);
		fh_new = (h32 < 32'd1) ? 32'd1 : ((h32 > MAX_HEIGHT) ? 32'(MAX_HEIGHT) : h32);
	end

	// box sum over the window and neighbour count
	always_comb begin
		int y, lo, hi, vc, hc, col;
		y  = int'(out_row_q);
		lo = (y - RAD < 0) ? 0 : y - RAD;
		hi = (y + RAD > int'(fh_q) - 1) ? int'(fh_q) - 1 : y + RAD;
		vc = hi - lo + 1;
		hc = 0;
		for (int ch = 0; ch < 3; ch++) begin
			acc_w[ch] = '0;
		end
		for (int k = 0; k < WIN; k++) begin
			col = int'(out_col_q) + RAD - k;
			if (col >= 0 && col < int'(fw_q)) begin
				hc = hc + 1;
				for (int ch = 0; ch < 3; ch++) begin
					acc_w[ch] = acc_w[ch] + ACW'(win_q[k][ch]);
				end
			end
		end
		dvs_w = DVW'(vc * hc);
	end

	// colour sphere test, centre read live against current registers
	always_comb begin
		logic signed [PW:0]   db, dg, dr;
		logic signed [2*PW+1:0] sb, sg, sr;
		logic [2*PW+2:0]      d2;
		db = $signed({1'b0, centre_q[PW-1:0]}) - $signed({1'b0, cfg.center_b});
		dg = $signed({1'b0, centre_q[2*PW-1:PW]}) - $signed({1'b0, cfg.center_g});
		dr = $signed({1'b0, centre_q[3*PW-1:2*PW]}) - $signed({1'b0, cfg.center_r});
		sb = db * db;
		sg = dg * dg;
		sr = dr * dr;
		d2 = (2*PW+3)'(sb) + (2*PW+3)'(sg) + (2*PW+3)'(sr);
		skin_w = (d2 <= (2*PW+3)'(cfg.dist_sq_max));
	end

	assign item_ready = (state_q == S_IDLE);
	assign div_start  = (state_q == S_DSTART);
	assign load       = (state_q == S_DIV) && div_done && (!m_valid_q || m_axis_tready);
	assign last_w     = (32'(out_row_q) == 32'(fh_q) - 32'd1) &&
	                    (32'(out_col_q) == 32'(fw_q) - 32'd1);
	assign mem_we     = (state_q == S_WR) && real_q;
	assign waddr      = MAW'(32'(in_slot_q) * MAX_WIDTH + 32'(in_col_q));
	assign raddr      = (state_q == S_EMIT) ?
	                    MAW'(32'(out_slot_q) * MAX_WIDTH + 32'(out_col_q)) :
	                    MAW'(32'(rslot_q) * MAX_WIDTH + 32'(in_col_q));

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[waddr] <= item_q.px;
		end
		rdata_q <= mem_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			active_q   <= 1'b0;
			fw_q       <= FWW'(1);
			fh_q       <= FHW'(1);
			delay_q    <= '0;
			n_q        <= '0;
			in_col_q   <= '0;
			in_row_q   <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			in_slot_q  <= '0;
			out_slot_q <= '0;
			m_valid_q  <= 1'b0;
			for (int k = 0; k < WIN; k++) begin
				for (int ch = 0; ch < 3; ch++) begin
					win_q[k][ch] <= '0;
				end
			end
		end else begin
			if (m_valid_q && m_axis_tready && !load) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						item_q <= item;
						if (active_q) begin
							state_q <= S_CHK;
						end else if (item.is_pixel) begin
							active_q   <= 1'b1;
							fw_q       <= FWW'(fw_new);
							fh_q       <= FHW'(fh_new);
							delay_q    <= NW'(RAD * fw_new + RAD);
							n_q        <= '0;
							in_col_q   <= '0;
							in_row_q   <= '0;
							out_col_q  <= '0;
							out_row_q  <= '0;
							in_slot_q  <= '0;
							out_slot_q <= '0;
							state_q    <= S_CHK;
						end
					end
				end
				S_CHK: begin
					if (32'(in_row_q) < 32'(fh_q) && !item_q.is_pixel) begin
						state_q <= S_IDLE;
					end else begin
						real_q  <= item_q.is_pixel && (32'(in_row_q) < 32'(fh_q));
						for (int ch = 0; ch < 3; ch++) begin
							sum_q[ch] <= (item_q.is_pixel && (32'(in_row_q) < 32'(fh_q))) ?
							             CSW'(item_q.px[ch*PW +: PW]) : '0;
						end
						d_q     <= DCW'(1);
						rslot_q <= (in_slot_q == '0) ? SW'(RING - 1) : in_slot_q - 1'b1;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					if (32'(d_q) > RING) begin
						state_q <= S_EMIT;
					end else begin
						inc_q   <= (32'(in_row_q) >= 32'(d_q)) &&
						           (32'(in_row_q) - 32'(d_q) < 32'(fh_q));
						state_q <= S_AC;
					end
				end
				S_AC: begin
					if (inc_q) begin
						for (int ch = 0; ch < 3; ch++) begin
							sum_q[ch] <= sum_q[ch] + CSW'(rdata_q[ch*PW +: PW]);
						end
					end
					d_q     <= d_q + 1'b1;
					rslot_q <= (rslot_q == '0) ? SW'(RING - 1) : rslot_q - 1'b1;
					state_q <= S_RD;
				end
				S_EMIT: begin
					for (int k = WIN - 1; k > 0; k--) begin
						win_q[k] <= win_q[k-1];
					end
					win_q[0] <= sum_q;
					state_q  <= (n_q >= delay_q) ? S_CTR : S_WR;
				end
				S_CTR: begin
					centre_q <= rdata_q;
					acc_q    <= acc_w;
					dvs_q    <= dvs_w;
					state_q  <= S_DSTART;
				end
				S_DSTART: begin
					skin_q  <= skin_w;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (load) begin
						m_valid_q <= 1'b1;
						m_user_q  <= skin_q;
						m_last_q  <= last_w;
						for (int ch = 0; ch < 3; ch++) begin
							m_data_q[ch*PW +: PW] <= skin_q ? div_quo[ch][PW-1:0] :
							                         centre_q[ch*PW +: PW];
						end
						if (last_w) begin
							active_q <= 1'b0;
						end else if (32'(out_col_q) + 32'd1 >= 32'(fw_q)) begin
							out_col_q  <= '0;
							out_row_q  <= out_row_q + 1'b1;
							out_slot_q <= (out_slot_q == SW'(RING - 1)) ? '0 : out_slot_q + 1'b1;
						end else begin
							out_col_q <= out_col_q + 1'b1;
						end
						state_q <= S_WR;
					end
				end
				S_WR: begin
					n_q <= n_q + 1'b1;
					if (32'(in_col_q) + 32'd1 >= 32'(fw_q)) begin
						in_col_q  <= '0;
						in_row_q  <= in_row_q + 1'b1;
						in_slot_q <= (in_slot_q == SW'(RING - 1)) ? '0 : in_slot_q + 1'b1;
					end else begin
						in_col_q <= in_col_q + 1'b1;
					end
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	skmbs_div #(
		.NUM_W(ACW),
		.DEN_W(DVW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (acc_q),
		.den   (dvs_q),
		.busy  (div_busy),
		.done  (div_done),
		.quo   (div_quo)
	);

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;
	assign m_axis_tlast  = m_last_q;

	`SKMBS_ASSERT_IMPL(a_we_state, mem_we, state_q == S_WR)
	`SKMBS_ASSERT_IMPL(a_div_idle, div_start, !div_busy)
	`SKMBS_ASSERT_NEXT(a_last_ends, load && last_w, !active_q && m_axis_tlast)

endmodule

// File: hw/rtl/skin_masked_box_smoothing_core.sv
// ----------------------------------------------------------------------------
// skin_masked_box_smoothing_core
// skin masked box mean filter over a bgr raster stream
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one beat per item: tdata holds the pixel, tuser marks a
//   drain tick. the first pixel beat while idle latches image_width and
//   image_height for that frame. after the whole frame, drain beats push the
//   last rows out.
//   m_axis gives one beat per frame pixel, delayed by rad rows plus rad
//   pixels; tuser is the skin flag, tlast marks the frame's last pixel.
//   cfg writes a register by index; write only while no beat is in flight.
//   steps: for each item the back end reads every stored row, with a read
//   and an accumulate state per row, plus fixed states; an item that emits
//   also waits on the bit-serial divider, which steps through each bit of
//   the 14-bit box sum after a setup step. ignored drains pass only the idle
//   and check states, and drains while idle are taken in the idle state.
//   a 4-entry queue lets the input side keep accepting while the back end
//   works; a stalled receiver holds the output register and the back end
//   waits on it. reset clears all control state; line buffer contents are
//   not cleared and are only read after they are written within a frame.
// ----------------------------------------------------------------------------
module skin_masked_box_smoothing_core #(
	parameter int KERNEL_SIZE = skmbs_pkg::KERNEL_SIZE_DEF,
	parameter int MAX_WIDTH   = skmbs_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT  = skmbs_pkg::MAX_HEIGHT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [skmbs_pkg::PX_W-1:0]       s_axis_tdata,  // in_b, in_g, in_r
	input  logic                             s_axis_tuser,  // req_type
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [skmbs_pkg::PX_W-1:0]       m_axis_tdata,  // out_b, out_g, out_r
	output logic                             m_axis_tuser,  // skin_flag
	output logic                             m_axis_tlast,  // frame_last
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [skmbs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [skmbs_pkg::CFG_DATA_W-1:0] cfg_data
);

	skmbs_pkg::cfg_t  cfg_q;
	skmbs_pkg::item_t q_item;
	logic             q_valid, q_ready;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_b    <= skmbs_pkg::RST_CENTER_B;
			cfg_q.center_g    <= skmbs_pkg::RST_CENTER_G;
			cfg_q.center_r    <= skmbs_pkg::RST_CENTER_R;
			cfg_q.dist_sq_max <= skmbs_pkg::RST_DIST_MAX;
			cfg_q.width       <= skmbs_pkg::RST_WIDTH;
			cfg_q.height      <= skmbs_pkg::RST_HEIGHT;
		end else if (cfg_valid) begin
			case (cfg_index)
				skmbs_pkg::CFG_CENTER_B: cfg_q.center_b    <= cfg_data[7:0];
				skmbs_pkg::CFG_CENTER_G: cfg_q.center_g    <= cfg_data[7:0];
				skmbs_pkg::CFG_CENTER_R: cfg_q.center_r    <= cfg_data[7:0];
				skmbs_pkg::CFG_DIST_MAX: cfg_q.dist_sq_max <= cfg_data[17:0];
				skmbs_pkg::CFG_WIDTH:    cfg_q.width       <= cfg_data[10:0];
				skmbs_pkg::CFG_HEIGHT:   cfg_q.height      <= cfg_data[11:0];
				default: begin
				end
			endcase
		end
	end

	skmbs_queue u_queue (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.q_valid      (q_valid),
		.q_ready      (q_ready),
		.q_item       (q_item)
	);

	skmbs_core #(
		.KERNEL_SIZE(KERNEL_SIZE),
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.item_valid   (q_valid),
		.item_ready   (q_ready),
		.item         (q_item),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

endmodule

// File: tb/skin_masked_box_smoothing_core_tb.sv
// ----------------------------------------------------------------------------
// skin_masked_box_smoothing_core_tb
// self-checking bench: frames of bgr beats are streamed in with random gaps on
// both sides. A behavioral smoothing predictor gives the expected result
// beats, which are compared field by field in order. Register writes happen
// between frames and cover the extremes of the centre, the limit and the
// smallest frame size.
// ----------------------------------------------------------------------------
module skin_masked_box_smoothing_core_tb;

	localparam int RING_ROWS = 6;
	localparam int LINE_LEN  = 1024;
	localparam int SETTLE    = 200;
	localparam int WATCHDOG  = 20000;

	typedef struct packed {
		logic [23:0] px;
		logic        skin;
		logic        last;
	} result_t;

	typedef struct {
		bit      drain;
		logic [23:0] px;
		bit      typed;
		result_t want;
	} dir_row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [skmbs_pkg::PX_W-1:0] s_axis_tdata = '0;
	logic s_axis_tuser = 0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [skmbs_pkg::PX_W-1:0] m_axis_tdata;
	logic m_axis_tuser;
	logic m_axis_tlast;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [skmbs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [skmbs_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	skin_masked_box_smoothing_core dut (.*);

	always #1 clk = ~clk;

	// predictor state
	logic [7:0]  sk_cb = skmbs_pkg::RST_CENTER_B, sk_cg = skmbs_pkg::RST_CENTER_G,
		sk_cr = skmbs_pkg::RST_CENTER_R;
	logic [17:0] sk_max = skmbs_pkg::RST_DIST_MAX;
	logic [10:0] reg_w = skmbs_pkg::RST_WIDTH;
	logic [11:0] reg_h = skmbs_pkg::RST_HEIGHT;
	logic [23:0] line_mem [0:RING_ROWS*LINE_LEN-1];
	int unsigned col_sum [0:6][0:2];
	int unsigned pos_col, pos_row, res_col, res_row, frm_w = 1, frm_h = 1;
	bit in_frame = 0;

	result_t expected_q[$];
	result_t head;
	dir_row_t dir_tab[$];
	int errs = 0, beats_in = 0, beats_out = 0, frames = 0, idle_cnt = 0;
	bit calm = 0, hold_req = 0;

	task automatic report(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		errs++;
	endtask

	task automatic smooth_step(input bit drain, input logic [23:0] px,
			output bit emit, output result_t res);
		int unsigned r, c, q0, q1, n, dly, vc, hc, d2, m;
		int unsigned sum [3];
		int unsigned acc [3];
		int lo, hi, d, col;
		logic [23:0] v, centre;
		bit real_px;
		emit = 0;
		res = '0;
		if (!in_frame) begin
			if (drain) return;
			frm_w = reg_w < 1 ? 1 : (reg_w > LINE_LEN ? LINE_LEN : reg_w);
			frm_h = reg_h < 1 ? 1 : (reg_h > 2048 ? 2048 : reg_h);
			pos_col = 0; pos_row = 0; res_col = 0; res_row = 0;
			in_frame = 1;
		end
		r = pos_row;
		c = pos_col;
		real_px = !drain && r < frm_h;
		if (!real_px && r < frm_h) return;
		q0 = r >= RING_ROWS ? r - RING_ROWS : 0;
		q1 = r < frm_h ? r : frm_h - 1;
		sum = '{0, 0, 0};
		for (int unsigned q = q0; q <= q1; q++) begin
			v = (q == r) ? px : line_mem[(q % RING_ROWS) * LINE_LEN + c];
			for (int ch = 0; ch < 3; ch++) sum[ch] += v[8*ch +: 8];
		end
		for (int k = 6; k > 0; k--) col_sum[k] = col_sum[k-1];
		for (int ch = 0; ch < 3; ch++) col_sum[0][ch] = sum[ch];
		n = r * frm_w + c;
		dly = 3 * frm_w + 3;
		emit = n >= dly;
		if (emit) begin
			centre = line_mem[(res_row % RING_ROWS) * LINE_LEN + res_col];
			d = int'(centre[7:0]) - int'(sk_cb);   d2 = d * d;
			d = int'(centre[15:8]) - int'(sk_cg);  d2 += d * d;
			d = int'(centre[23:16]) - int'(sk_cr); d2 += d * d;
			res.skin = d2 <= sk_max;
			lo = int'(res_row) - 3 < 0 ? 0 : int'(res_row) - 3;
			hi = int'(res_row) + 3 > int'(frm_h) - 1 ? int'(frm_h) - 1 : int'(res_row) + 3;
			vc = hi - lo + 1;
			hc = 0;
			acc = '{0, 0, 0};
			for (int k = 0; k < 7; k++) begin
				col = int'(res_col) + 3 - k;
				if (col >= 0 && col < int'(frm_w)) begin
					hc++;
					for (int ch = 0; ch < 3; ch++) acc[ch] += col_sum[k][ch];
				end
			end
			for (int ch = 0; ch < 3; ch++) begin
				m = acc[ch] / (vc * hc);
				res.px[8*ch +: 8] = res.skin ? m[7:0] : centre[8*ch +: 8];
			end
			res.last = res_row == frm_h - 1 && res_col == frm_w - 1;
			if (res.last) in_frame = 0;
			else if (++res_col >= frm_w) begin
				res_col = 0;
				res_row++;
			end
		end
		if (real_px) line_mem[(r % RING_ROWS) * LINE_LEN + c] = px;
		if (++pos_col >= frm_w) begin
			pos_col = 0;
			pos_row++;
		end
	endtask

	task automatic reg_write(input logic [skmbs_pkg::CFG_IDX_W-1:0] idx,
			input logic [17:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			skmbs_pkg::CFG_CENTER_B: sk_cb = val[7:0];
			skmbs_pkg::CFG_CENTER_G: sk_cg = val[7:0];
			skmbs_pkg::CFG_CENTER_R: sk_cr = val[7:0];
			skmbs_pkg::CFG_DIST_MAX: sk_max = val;
			skmbs_pkg::CFG_WIDTH:    reg_w = val[10:0];
			skmbs_pkg::CFG_HEIGHT:   reg_h = val[11:0];
			default: ;
		endcase
	endtask

	// one beat on the input; the predicted result is queued first
	task automatic push_beat(input bit drain, input logic [23:0] px,
			input bit typed, input result_t want);
		bit emit;
		result_t res;
		smooth_step(drain, px, emit, res);
		if (emit) expected_q.push_back(typed ? want : res);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tuser <= drain;
		s_axis_tdata <= px;
		do @(posedge clk); while (!s_axis_tready);
		beats_in++;
	endtask

	task automatic quiesce;
		s_axis_tvalid <= 0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic [7:0] near(input logic [7:0] ctr);
		int v;
		v = int'(ctr) + $urandom_range(0, 80) - 40;
		return v < 0 ? 8'd0 : (v > 255 ? 8'd255 : v[7:0]);
	endfunction

	function automatic dir_row_t mk(input bit drain, input logic [23:0] px,
			input bit typed, input logic [23:0] wpx, input bit wskin);
		mk.drain = drain;
		mk.px = px;
		mk.typed = typed;
		mk.want = '{wpx, wskin, 1'b1};
	endfunction

	// receiver with random stalls and one long hold-off
	initial begin
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				m_axis_tready <= 0;
				repeat (400) @(posedge clk);
				hold_req = 0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				m_axis_tready <= 0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end else begin
				m_axis_tready <= 1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			beats_out++;
			if (expected_q.size() == 0) report("result beat with nothing expected");
			else begin
				head = expected_q.pop_front();
				if (m_axis_tdata[7:0] !== head.px[7:0])
					report($sformatf("out_b %0d want %0d", m_axis_tdata[7:0], head.px[7:0]));
				if (m_axis_tdata[15:8] !== head.px[15:8])
					report($sformatf("out_g %0d want %0d", m_axis_tdata[15:8], head.px[15:8]));
				if (m_axis_tdata[23:16] !== head.px[23:16])
					report($sformatf("out_r %0d want %0d", m_axis_tdata[23:16],
						head.px[23:16]));
				if (m_axis_tuser !== head.skin)
					report($sformatf("skin_flag %b want %b", m_axis_tuser, head.skin));
				if (m_axis_tlast !== head.last)
					report($sformatf("frame_last %b want %b", m_axis_tlast, head.last));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt > WATCHDOG) begin
			$display("timeout with %0d results outstanding", expected_q.size());
			$display("skin_masked_box_smoothing_core: mismatch");
			$finish;
		end
	end

	initial begin
		bit started;
		logic [23:0] px;
		logic [10:0] w;
		logic [11:0] h;
		result_t none;
		none = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// 1x1 frames: a lone pixel is its own mean, so results read off directly
		reg_write(skmbs_pkg::CFG_WIDTH, 18'd1);
		reg_write(skmbs_pkg::CFG_HEIGHT, 18'd1);
		cfg_valid <= 0;
		dir_tab.push_back(mk(1, 24'h5A5A5A, 0, 0, 0));
		dir_tab.push_back(mk(0, 24'hC6A194, 0, 0, 0));
		repeat (5) dir_tab.push_back(mk(1, 24'h0, 0, 0, 0));
		dir_tab.push_back(mk(1, 24'h0, 1, 24'hC6A194, 1));
		dir_tab.push_back(mk(0, 24'hFFFFFF, 0, 0, 0));
		repeat (5) dir_tab.push_back(mk(1, 24'hFFFFFF, 0, 0, 0));
		dir_tab.push_back(mk(1, 24'hFFFFFF, 1, 24'hFFFFFF, 0));
		dir_tab.push_back(mk(0, 24'h000000, 0, 0, 0));
		// pixels past the frame end count as drain ticks
		repeat (5) dir_tab.push_back(mk(0, 24'hA5C33C, 0, 0, 0));
		dir_tab.push_back(mk(0, 24'h123456, 1, 24'h000000, 0));
		foreach (dir_tab[i]) push_beat(dir_tab[i].drain, dir_tab[i].px, dir_tab[i].typed,
			dir_tab[i].want);
		quiesce();

		while (beats_in < 2000 || frames < 8) begin
			case (frames)
				0: begin w = 0;    h = 0;    end
				1: begin w = 64;   h = 1;    end
				2: begin w = 1;    h = 40;   end
				3: begin w = 40;   h = 2;    end
				4: begin w = 40;   h = 12;   end
				5: begin w = 1;    h = 30;   end
				default: begin
					w = $urandom_range(1, 12);
					h = $urandom_range(1, 9);
				end
			endcase
			reg_write(skmbs_pkg::CFG_WIDTH, {7'($urandom), w});
			reg_write(skmbs_pkg::CFG_HEIGHT, {6'($urandom), h});
			if (frames == 5) begin
				reg_write(skmbs_pkg::CFG_CENTER_B, {10'($urandom), 8'd0});
				reg_write(skmbs_pkg::CFG_CENTER_G, {10'($urandom), 8'd0});
				reg_write(skmbs_pkg::CFG_CENTER_R, {10'($urandom), 8'd0});
			end else if (frames == 6) begin
				reg_write(skmbs_pkg::CFG_CENTER_B, {10'($urandom), 8'd255});
				reg_write(skmbs_pkg::CFG_CENTER_G, {10'($urandom), 8'd255});
				reg_write(skmbs_pkg::CFG_CENTER_R, {10'($urandom), 8'd255});
			end else if ($urandom_range(0, 1)) begin
				reg_write(skmbs_pkg::CFG_CENTER_B, 18'($urandom));
				reg_write(skmbs_pkg::CFG_CENTER_G, 18'($urandom));
				reg_write(skmbs_pkg::CFG_CENTER_R, 18'($urandom));
			end
			case (frames)
				0: reg_write(skmbs_pkg::CFG_DIST_MAX, 18'd0);
				1: reg_write(skmbs_pkg::CFG_DIST_MAX, 18'd195075);
				3: reg_write(skmbs_pkg::CFG_DIST_MAX, 18'h3FFFF);
				default: if ($urandom_range(0, 1))
					reg_write(skmbs_pkg::CFG_DIST_MAX, 18'($urandom_range(0, 12000)));
			endcase
			cfg_valid <= 0;
			calm = beats_in > 1700;
			started = 0;
			do begin
				if ($urandom_range(0, 1))
					px = {near(sk_cr), near(sk_cg), near(sk_cb)};
				else
					px = 24'($urandom);
				if (!started) begin
					if ($urandom_range(0, 19) == 0) push_beat(1, px, 0, none);
					else begin
						push_beat(0, px, 0, none);
						started = 1;
					end
				end else if (pos_row < frm_h)
					push_beat($urandom_range(0, 19) == 0, px, 0, none);
				else
					push_beat($urandom_range(0, 4) != 0, px, 0, none);
				// long hold-off once results are flowing
				if (frames == 4 && pos_row == 5 && pos_col == 0) hold_req = 1;
			end while (in_frame);
			frames++;
			quiesce();
		end

		if (expected_q.size() != 0) report("results still outstanding at the end");
		$display("%0d frames from 1x1 up to 64 wide and 40 tall, one long output hold-off",
			frames + 3);
		$display("%0d input beats sent, %0d result beats checked", beats_in, beats_out);
		if (errs == 0)
			$display("skin_masked_box_smoothing_core: match");
		else
			$display("skin_masked_box_smoothing_core: mismatch");
		$finish;
	end

endmodule
